@@ hw/rtl/iodma_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU offset, dead zone and moving average: shared definitions
// Field widths, window geometry, register indexes and reset values.
// ----------------------------------------------------------------------------
package iodma_pkg;

  localparam int SMP_W    = 24;
  localparam int DIFF_W   = SMP_W + 1;
  localparam int MAG_W    = 23;
  localparam int WIN_LOG2 = 3;
  localparam int WIN_LEN  = 1 << WIN_LOG2;
  localparam int SUM_W    = MAG_W + WIN_LOG2;
  localparam int CFG_W    = 24;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic        [MAG_W-1:0] mag_t;
  typedef logic        [SUM_W-1:0] sum_t;

  typedef enum logic [2:0] {
    REG_ACCEL_X_OFS = 3'd0,
    REG_ACCEL_Y_OFS = 3'd1,
    REG_GYRO_X_OFS  = 3'd2,
    REG_GYRO_Y_OFS  = 3'd3,
    REG_GYRO_Z_OFS  = 3'd4,
    REG_GYRO_XY_DZ  = 3'd5,
    REG_GYRO_Z_DZ   = 3'd6
  } reg_idx_t;

  localparam mag_t GYRO_XY_DZ_RST = MAG_W'(256);
  localparam mag_t GYRO_Z_DZ_RST  = MAG_W'(64);

  typedef struct packed {
    logic shift_en;
    mag_t mag;
  } win_ctl_t;

endpackage

@@ hw/rtl/iodma_axis.sv @@
// ----------------------------------------------------------------------------
// IMU axis conditioner
// Offset subtraction, optional dead zone and saturation to 24 bits.
// ----------------------------------------------------------------------------
module iodma_axis import iodma_pkg::*; (
  input  smp_t smp,
  input  smp_t ofs,
  input  mag_t limit,
  input  logic dz_en,
  output smp_t res
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] lim_pos;
  logic signed [DIFF_W-1:0] lim_neg;
  logic signed [DIFF_W-1:0] kept;
  logic                     keep;

  assign diff    = DIFF_W'(smp) - DIFF_W'(ofs);
  assign lim_pos = $signed({2'b00, limit});
  assign lim_neg = -lim_pos;
  assign keep    = !dz_en || (diff > lim_pos) || (diff < lim_neg);
  assign kept    = keep ? diff : '0;

  always_comb begin
    if (kept[DIFF_W-1] != kept[DIFF_W-2]) begin
      res = kept[DIFF_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      res = kept[SMP_W-1:0];
    end
  end

endmodule

@@ hw/rtl/iodma_cell.sv @@
// ----------------------------------------------------------------------------
// Window cell
// Holds one window entry and hands it to the next cell on each shift.
// ----------------------------------------------------------------------------
module iodma_cell import iodma_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  mag_t d,
  output mag_t q
);

  mag_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (shift_en) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

@@ hw/rtl/iodma_window.sv @@
// ----------------------------------------------------------------------------
// Moving average window
// Chain of cells with a running sum; gives the mean after the new entry.
// ----------------------------------------------------------------------------
module iodma_window import iodma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  win_ctl_t ctl,
  output mag_t     mean_nxt
);

  mag_t tap [WIN_LEN+1];
  sum_t sum_r;
  sum_t sum_nxt;

  assign tap[0] = ctl.mag;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    iodma_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.shift_en),
      .d        (tap[i]),
      .q        (tap[i+1])
    );
  end

  assign sum_nxt  = sum_r - SUM_W'(tap[WIN_LEN]) + SUM_W'(ctl.mag);
  assign mean_nxt = sum_nxt[SUM_W-1:WIN_LOG2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.shift_en) begin
      sum_r <= sum_nxt;
    end
  end

  a_cell0_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_en |=> tap[1] == $past(ctl.mag))
    else $error("first cell missed the new entry");

  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.shift_en |=> $stable(sum_r) && $stable(tap[WIN_LEN]))
    else $error("window changed without a shift");

  a_sum_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> sum_r == '0)
    else $error("running sum not cleared by reset");

endmodule

@@ hw/rtl/imu_offset_deadzone_moving_average.sv @@
// ----------------------------------------------------------------------------
// IMU offset removal, gyro dead zone and gyro y moving average
// Conditions five axes of each six-axis sample; averages gyro y magnitude.
// ----------------------------------------------------------------------------
// Input channel in_*: one sample per item, taken when in_valid is high and
// in_stall is low. Result channel out_*: one result per item, in order,
// taken when out_valid is high and out_stall is low.
// An accepted item is registered in the input stage, then in the output
// register, which raises out_valid. Throughput is one item per cycle while
// out_stall is low: the input stage registers the conditioned axes, the
// output register performs the window shift and running sum update.
// When the receiver stalls, the result holds in the output register and
// the input stage still takes one more item; in_stall rises only when both
// stages are full.
// The cfg_* port writes the offsets and dead zones; write only while idle.
// Reset (rst_n low, synchronous) empties both stages, zeroes the window and
// its sum, clears the offsets and restores the dead zones to 1.0 and 0.25.
// ----------------------------------------------------------------------------
module imu_offset_deadzone_moving_average import iodma_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  smp_t             in_accel_x_in,
  input  smp_t             in_accel_y_in,
  input  smp_t             in_accel_z_in,
  input  smp_t             in_gyro_x_in,
  input  smp_t             in_gyro_y_in,
  input  smp_t             in_gyro_z_in,
  output logic             out_valid,
  input  logic             out_stall,
  output smp_t             out_accel_x_out,
  output smp_t             out_accel_y_out,
  output smp_t             out_accel_z_out,
  output smp_t             out_gyro_x_out,
  output smp_t             out_gyro_y_out,
  output smp_t             out_gyro_z_out,
  output mag_t             out_gyro_y_mean
);

  smp_t ax_ofs_r, ay_ofs_r, gx_ofs_r, gy_ofs_r, gz_ofs_r;
  mag_t gxy_dz_r, gz_dz_r;

  smp_t ax_c, ay_c, gx_c, gy_c, gz_c;
  logic [SMP_W-1:0] gy_abs;
  mag_t mag_c;

  logic a_vld_r;
  smp_t a_ax_r, a_ay_r, a_az_r, a_gx_r, a_gy_r, a_gz_r;
  mag_t mag_r;

  logic b_vld_r;
  smp_t b_ax_r, b_ay_r, b_az_r, b_gx_r, b_gy_r, b_gz_r;
  mag_t b_mean_r;

  logic     a_ld;
  logic     b_ld;
  win_ctl_t win_ctl;
  mag_t     mean_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_ofs_r <= '0;
      ay_ofs_r <= '0;
      gx_ofs_r <= '0;
      gy_ofs_r <= '0;
      gz_ofs_r <= '0;
      gxy_dz_r <= GYRO_XY_DZ_RST;
      gz_dz_r  <= GYRO_Z_DZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ACCEL_X_OFS: ax_ofs_r <= cfg_wdata;
        REG_ACCEL_Y_OFS: ay_ofs_r <= cfg_wdata;
        REG_GYRO_X_OFS:  gx_ofs_r <= cfg_wdata;
        REG_GYRO_Y_OFS:  gy_ofs_r <= cfg_wdata;
        REG_GYRO_Z_OFS:  gz_ofs_r <= cfg_wdata;
        REG_GYRO_XY_DZ:  gxy_dz_r <= cfg_wdata[MAG_W-1:0];
        REG_GYRO_Z_DZ:   gz_dz_r  <= cfg_wdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  iodma_axis u_ax (.smp(in_accel_x_in), .ofs(ax_ofs_r), .limit(gxy_dz_r), .dz_en(1'b0),
                   .res(ax_c));
  iodma_axis u_ay (.smp(in_accel_y_in), .ofs(ay_ofs_r), .limit(gxy_dz_r), .dz_en(1'b0),
                   .res(ay_c));
  iodma_axis u_gx (.smp(in_gyro_x_in), .ofs(gx_ofs_r), .limit(gxy_dz_r), .dz_en(1'b1),
                   .res(gx_c));
  iodma_axis u_gy (.smp(in_gyro_y_in), .ofs(gy_ofs_r), .limit(gxy_dz_r), .dz_en(1'b1),
                   .res(gy_c));
  iodma_axis u_gz (.smp(in_gyro_z_in), .ofs(gz_ofs_r), .limit(gz_dz_r), .dz_en(1'b1),
                   .res(gz_c));

  // full-scale negative has no 23-bit magnitude: clamp
  assign gy_abs = gy_c[SMP_W-1] ? (~gy_c + SMP_W'(1)) : gy_c;
  assign mag_c  = gy_abs[SMP_W-1] ? {MAG_W{1'b1}} : gy_abs[MAG_W-1:0];

  assign b_ld     = a_vld_r && (!b_vld_r || !out_stall);
  assign in_stall = a_vld_r && !b_ld;
  assign a_ld     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ld || b_ld) begin
      a_vld_r <= a_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_ax_r <= ax_c;
      a_ay_r <= ay_c;
      a_az_r <= in_accel_z_in;
      a_gx_r <= gx_c;
      a_gy_r <= gy_c;
      a_gz_r <= gz_c;
      mag_r  <= mag_c;
    end
  end

  assign win_ctl.shift_en = b_ld;
  assign win_ctl.mag      = mag_r;

  iodma_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (win_ctl),
    .mean_nxt (mean_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ld || !out_stall) begin
      b_vld_r <= b_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ld) begin
      b_ax_r   <= a_ax_r;
      b_ay_r   <= a_ay_r;
      b_az_r   <= a_az_r;
      b_gx_r   <= a_gx_r;
      b_gy_r   <= a_gy_r;
      b_gz_r   <= a_gz_r;
      b_mean_r <= mean_nxt;
    end
  end

  assign out_valid       = b_vld_r;
  assign out_accel_x_out = b_ax_r;
  assign out_accel_y_out = b_ay_r;
  assign out_accel_z_out = b_az_r;
  assign out_gyro_x_out  = b_gx_r;
  assign out_gyro_y_out  = b_gy_r;
  assign out_gyro_z_out  = b_gz_r;
  assign out_gyro_y_mean = b_mean_r;

  a_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> a_vld_r)
    else $error("accepted item did not reach the input stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !b_ld |=> a_vld_r && $stable(mag_r) && $stable(a_gy_r))
    else $error("input stage lost or changed a waiting item");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && !out_stall && !b_ld |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule
